@@ rtl/core/dctb_pkg.sv @@
// Shared types, constants and arithmetic helpers for the tile decoder.
package dctb_pkg;

   localparam int TileItems  = 192;
   localparam int PlaneSize  = 64;
   localparam int DqAddrBits = 8;
   localparam int ColAddrBits = 6;

   typedef struct packed {
      logic signed [15:0] coefficient;
      logic [15:0]        quant_factor;
   } req_item_type;

   typedef struct packed {
      logic [31:0] pixel_bgra;
      logic        last_pixel;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_COL_RD,
      ST_COL_MUL,
      ST_COL_WR,
      ST_ROW_RD,
      ST_ROW_MUL,
      ST_ROW_WR,
      ST_PIX_RD,
      ST_PIX_CB,
      ST_PIX_OUT
   } state_type;

   // Saturate a signed 32-bit value to 0..255.
   function automatic logic [7:0] sat_u8(input logic signed [31:0] v);
      logic [7:0] r;
      if (v < 0) r = 8'd0;
      else if (v > 32'sd255) r = 8'd255;
      else r = v[7:0];
      return r;
   endfunction

endpackage

@@ rtl/core/dctb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module dctb_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/dctb_idct8.sv @@
// One 8-point islow IDCT pass over a registered vector, two pipeline stages.
module dctb_idct8 (
   input  logic        clock,
   input  logic [31:0] s_in [8],
   input  logic [31:0] bias,
   output logic [31:0] o_out [8]
);
   import dctb_pkg::*;

   // stage 1: products
   logic [31:0] pe_ff [6];
   logic [31:0] po_ff [12];
   logic [31:0] pe_in [6];
   logic [31:0] po_in [12];
   logic [31:0] p3s, p4s, p1s, p2s, p2e, p3e;

   always_comb begin
      p2e = s_in[2];
      p3e = s_in[6];
      pe_in[0] = (p2e + p3e) * 32'd2217;
      pe_in[1] = p3e * (32'd0 - 32'd7567);
      pe_in[2] = p2e * 32'd3135;
      pe_in[3] = (s_in[0] + s_in[4]) << 12;
      pe_in[4] = (s_in[0] - s_in[4]) << 12;
      pe_in[5] = bias;
      p3s = s_in[7] + s_in[3];
      p4s = s_in[5] + s_in[1];
      p1s = s_in[7] + s_in[1];
      p2s = s_in[5] + s_in[3];
      po_in[0]  = (p3s + p4s) * 32'd4816;
      po_in[1]  = s_in[7] * 32'd1223;
      po_in[2]  = s_in[5] * 32'd8410;
      po_in[3]  = s_in[3] * 32'd12586;
      po_in[4]  = s_in[1] * 32'd6149;
      po_in[5]  = p1s * (32'd0 - 32'd3685);
      po_in[6]  = p2s * (32'd0 - 32'd10497);
      po_in[7]  = p3s * (32'd0 - 32'd8034);
      po_in[8]  = p4s * (32'd0 - 32'd1597);
      po_in[9]  = 32'd0;
      po_in[10] = 32'd0;
      po_in[11] = 32'd0;
   end

   always_ff @(posedge clock) begin
      pe_ff <= pe_in;
      po_ff <= po_in;
   end

   // stage 2: butterflies
   logic [31:0] t0, t1, t2, t3, x0, x1, x2, x3, a1, a2, u0, u1, u2, u3;
   always_comb begin
      t2 = pe_ff[0] + pe_ff[1];
      t3 = pe_ff[0] + pe_ff[2];
      x0 = pe_ff[3] + t3 + pe_ff[5];
      x3 = pe_ff[3] - t3 + pe_ff[5];
      x1 = pe_ff[4] + t2 + pe_ff[5];
      x2 = pe_ff[4] - t2 + pe_ff[5];
      a1 = po_ff[0] + po_ff[5];
      a2 = po_ff[0] + po_ff[6];
      u3 = po_ff[4] + a1 + po_ff[8];
      u2 = po_ff[3] + a2 + po_ff[7];
      u1 = po_ff[2] + a2 + po_ff[8];
      u0 = po_ff[1] + a1 + po_ff[7] + po_ff[9] + po_ff[10] + po_ff[11];
      t0 = u0; t1 = u1;
      o_out[0] = x0 + u3; o_out[7] = x0 - u3;
      o_out[1] = x1 + u2; o_out[6] = x1 - u2;
      o_out[2] = x2 + t1; o_out[5] = x2 - t1;
      o_out[3] = x3 + t0; o_out[4] = x3 - t0;
   end
endmodule

@@ rtl/core/dct_tile_to_bgra_decoder.sv @@
// Top level: coefficient load, two-pass IDCT per plane, YCbCr to BGRA output.
//
//  channel | ports                      | direction
//  req     | start, busy, req_item      | in, 192 items per tile
//  rsp     | rsp_valid, rsp_item        | out, 64 items per tile
//
// Each cycle with start high loads one coefficient (dequant RAM write).
// After the 192nd item busy rises: per plane 8 column and 8 row vectors, each
// read from RAM (registered read), run through the IDCT unit and written back;
// then 64 pixels, each from three sample-RAM reads.
// Reset is synchronous and clears the sequencer and counters only.
// The receiver cannot stall; results are shown one cycle each with rsp_valid.
module dct_tile_to_bgra_decoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  dctb_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output dctb_pkg::rsp_item_type rsp_item
);
   import dctb_pkg::*;

   state_type state_ff, state_in;
   logic [7:0] cnt_ff, cnt_in;      // load index / pixel index
   logic [1:0] plane_ff, plane_in;
   logic [2:0] vec_ff, vec_in;      // column or row number
   logic [3:0] k_ff, k_in;          // element within vector
   logic [31:0] s_ff [8];
   logic [31:0] o_w [8];
   logic [31:0] o_ff [8];
   logic [1:0]  dly_ff, dly_in;
   logic [7:0]  ysmp_ff, cbsmp_ff;

   // RAM ports
   logic        dq_we;
   logic [7:0]  dq_wa, dq_ra;
   logic [15:0] dq_wd, dq_rd;
   logic        cp_we;
   logic [5:0]  cp_wa, cp_ra;
   logic [31:0] cp_wd, cp_rd;
   logic        sp_we;
   logic [7:0]  sp_wa, sp_ra;
   logic [7:0]  sp_wd, sp_rd;

   dctb_ram #(.Width(16), .Depth(TileItems)) u_dq (
      .clock, .wr_en(dq_we), .wr_addr(dq_wa), .wr_data(dq_wd),
      .rd_addr(dq_ra), .rd_data(dq_rd));
   dctb_ram #(.Width(32), .Depth(PlaneSize)) u_cp (
      .clock, .wr_en(cp_we), .wr_addr(cp_wa), .wr_data(cp_wd),
      .rd_addr(cp_ra), .rd_data(cp_rd));
   dctb_ram #(.Width(8), .Depth(TileItems)) u_sp (
      .clock, .wr_en(sp_we), .wr_addr(sp_wa), .wr_data(sp_wd),
      .rd_addr(sp_ra), .rd_data(sp_rd));

   logic [31:0] bias;
   assign bias = (state_ff inside {ST_ROW_RD, ST_ROW_MUL, ST_ROW_WR})
                 ? (32'd65536 + (32'd128 << 17)) : 32'd512;

   dctb_idct8 u_idct (.clock, .s_in(s_ff), .bias, .o_out(o_w));

   logic accept;
   logic [31:0] prod;
   logic [7:0] base;
   assign accept = start && !busy;
   assign prod = 32'(signed'(req_item.coefficient)) * {16'd0, req_item.quant_factor};
   assign base = {plane_ff, 6'd0};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:    if (accept && cnt_ff == 8'(TileItems - 1)) state_in = ST_COL_RD;
         ST_COL_RD:  if (k_ff == 4'd8) state_in = ST_COL_MUL;
         ST_COL_MUL: if (dly_ff == 2'd2) state_in = ST_COL_WR;
         ST_COL_WR:  if (k_ff == 4'd7) state_in = (vec_ff == 3'd7) ? ST_ROW_RD : ST_COL_RD;
         ST_ROW_RD:  if (k_ff == 4'd8) state_in = ST_ROW_MUL;
         ST_ROW_MUL: if (dly_ff == 2'd2) state_in = ST_ROW_WR;
         ST_ROW_WR:  if (k_ff == 4'd7) begin
            if (vec_ff != 3'd7) state_in = ST_ROW_RD;
            else if (plane_ff == 2'd2) state_in = ST_PIX_RD;
            else state_in = ST_COL_RD;
         end
         ST_PIX_RD:  state_in = ST_PIX_CB;
         ST_PIX_CB:  state_in = ST_PIX_OUT;
         ST_PIX_OUT: state_in = (cnt_ff == 8'd63) ? ST_LOAD : ST_PIX_RD;
         default:    state_in = ST_LOAD;
      endcase
   end

   // counters and datapath controls
   always_comb begin
      cnt_in = cnt_ff; plane_in = plane_ff; vec_in = vec_ff; k_in = k_ff;
      dly_in = 2'd0;
      dq_we = 1'b0; dq_wa = cnt_ff; dq_wd = prod[15:0];
      dq_ra = base + {2'd0, k_ff[2:0], vec_ff};
      cp_we = 1'b0; cp_wa = {k_ff[2:0], vec_ff}; cp_wd = '0;
      cp_ra = {vec_ff, k_ff[2:0]};
      sp_we = 1'b0; sp_wa = base + {2'd0, vec_ff, k_ff[2:0]}; sp_wd = '0;
      sp_ra = cnt_ff;
      case (state_ff)
         ST_LOAD: if (accept) begin
            dq_we = 1'b1;
            if (cnt_ff == 8'(TileItems - 1)) begin
               cnt_in = '0; plane_in = '0; vec_in = '0; k_in = '0;
            end else cnt_in = cnt_ff + 8'd1;
         end
         ST_COL_RD, ST_ROW_RD: k_in = (k_ff == 4'd8) ? 4'd0 : k_ff + 4'd1;
         ST_COL_MUL, ST_ROW_MUL: dly_in = dly_ff + 2'd1;
         ST_COL_WR: begin
            cp_we = 1'b1;
            cp_wd = 32'($signed(o_ff[k_ff[2:0]]) >>> 10);
            k_in = (k_ff == 4'd7) ? 4'd0 : k_ff + 4'd1;
            if (k_ff == 4'd7) vec_in = vec_ff + 3'd1;
         end
         ST_ROW_WR: begin
            sp_we = 1'b1;
            sp_wd = sat_u8($signed(o_ff[k_ff[2:0]]) >>> 17);
            k_in = (k_ff == 4'd7) ? 4'd0 : k_ff + 4'd1;
            if (k_ff == 4'd7) begin
               vec_in = vec_ff + 3'd1;
               if (vec_ff == 3'd7) begin
                  plane_in = plane_ff + 2'd1;
                  cnt_in = '0;
               end
            end
         end
         ST_PIX_RD: sp_ra = 8'd64 + cnt_ff;
         ST_PIX_CB: sp_ra = 8'd128 + cnt_ff;
         ST_PIX_OUT: begin
            // fetch Y of the next pixel
            cnt_in = (cnt_ff == 8'd63) ? 8'd0 : cnt_ff + 8'd1;
            sp_ra = cnt_ff + 8'd1;
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; cnt_ff <= '0; plane_ff <= '0; vec_ff <= '0;
         k_ff <= '0; dly_ff <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; plane_ff <= plane_in;
         vec_ff <= vec_in; k_ff <= k_in; dly_ff <= dly_in;
      end
   end

   // gather RAM data (the cycle after its address), IDCT result, samples
   always_ff @(posedge clock) begin
      if (state_ff == ST_COL_RD && k_ff != 4'd0)
         s_ff[k_ff[2:0] - 3'd1] <= {{16{dq_rd[15]}}, dq_rd};
      if (state_ff == ST_ROW_RD && k_ff != 4'd0)
         s_ff[k_ff[2:0] - 3'd1] <= cp_rd;
      if ((state_ff == ST_COL_MUL || state_ff == ST_ROW_MUL) && dly_ff == 2'd1)
         o_ff <= o_w;
      if (state_ff == ST_PIX_RD) ysmp_ff <= sp_rd;
      if (state_ff == ST_PIX_CB) cbsmp_ff <= sp_rd;
   end

   // color conversion for the current pixel (Y reg, Cb reg, Cr on RAM data)
   logic signed [31:0] yf, cb, cr, gcb, r, g, b;
   always_comb begin
      yf  = ($signed({24'd0, ysmp_ff}) <<< 20) + 32'sd524288;
      cb  = $signed({24'd0, cbsmp_ff}) - 32'sd128;
      cr  = $signed({24'd0, sp_rd}) - 32'sd128;
      gcb = cb * -32'sd360960;
      gcb = gcb - $signed({16'd0, gcb[15:0]});
      r   = (yf + cr * 32'sd1470208) >>> 20;
      g   = (yf + cr * -32'sd748800 + gcb) >>> 20;
      b   = (yf + cb * 32'sd1858048) >>> 20;
   end

   // outputs
   always_comb begin
      busy = (state_ff != ST_LOAD);
      rsp_valid = (state_ff == ST_PIX_OUT);
      rsp_item.pixel_bgra = {8'hff, sat_u8(r), sat_u8(g), sat_u8(b)};
      rsp_item.last_pixel = (state_ff == ST_PIX_OUT) && (cnt_ff == 8'd63);
   end
endmodule

@@ rtl/core/dctb_checker.sv @@
// Port-level checks for the tile decoder, bound to the top level.
module dctb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input dctb_pkg::rsp_item_type rsp_item
);
   import dctb_pkg::*;

   // results only while busy
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   // alpha is always 255
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.pixel_bgra[31:24] == 8'hff) else $error("alpha");
   // last pixel ends busy
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last_pixel) |=> !busy) else $error("last");
   // results are spaced
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back");
   // busy only rises after an accepted item
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !busy) else $error("busy without item");
endmodule

bind dct_tile_to_bgra_decoder dctb_checker u_chk (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_item);

@@ test/tb_dct_tile_to_bgra_decoder.sv @@
// Testbench for the tile decoder: predicts every BGRA pixel of each tile and checks it.
`timescale 1ns / 100ps

module tb_dct_tile_to_bgra_decoder;
   import dctb_pkg::*;

   localparam int IdleLimit = 20000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   dct_tile_to_bgra_decoder dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   // predictor state
   logic [15:0]  coef_products[TileItems];
   logic [31:0]  col_scratch[PlaneSize];
   logic [7:0]   samples[TileItems];
   int           tile_pos;

   req_item_type pending_items[$];
   rsp_item_type expected_pixels[$];
   int           error_count;
   int           pixels_seen;
   int           idle_cycles;
   bit           stim_done;
   bit           steady;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic signed [31:0] asr(input logic signed [31:0] v, input int s);
      return v >>> s;
   endfunction

   function automatic logic [7:0] clamp8(input logic signed [31:0] v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   // one 8-point islow pass, all arithmetic wraps at 32 bits
   task automatic idct_1d(input logic [31:0] s[8], input logic [31:0] bias,
                          output logic [31:0] o[8]);
      logic [31:0] p1, p2, p3, p4, p5, t0, t1, t2, t3, x0, x1, x2, x3;
      p2 = s[2]; p3 = s[6];
      p1 = (p2 + p3) * 32'd2217;
      t2 = p1 + p3 * (-32'sd7567);
      t3 = p1 + p2 * 32'd3135;
      p2 = s[0]; p3 = s[4];
      t0 = (p2 + p3) << 12;
      t1 = (p2 - p3) << 12;
      x0 = t0 + t3 + bias; x3 = t0 - t3 + bias;
      x1 = t1 + t2 + bias; x2 = t1 - t2 + bias;
      t0 = s[7]; t1 = s[5]; t2 = s[3]; t3 = s[1];
      p3 = t0 + t2; p4 = t1 + t3; p1 = t0 + t3; p2 = t1 + t2;
      p5 = (p3 + p4) * 32'd4816;
      t0 = t0 * 32'd1223; t1 = t1 * 32'd8410; t2 = t2 * 32'd12586; t3 = t3 * 32'd6149;
      p1 = p5 + p1 * (-32'sd3685);
      p2 = p5 + p2 * (-32'sd10497);
      p3 = p3 * (-32'sd8034); p4 = p4 * (-32'sd1597);
      t3 = t3 + p1 + p4; t2 = t2 + p2 + p3; t1 = t1 + p2 + p4; t0 = t0 + p1 + p3;
      o[0] = x0 + t3; o[7] = x0 - t3;
      o[1] = x1 + t2; o[6] = x1 - t2;
      o[2] = x2 + t1; o[5] = x2 - t1;
      o[3] = x3 + t0; o[4] = x3 - t0;
   endtask

   task automatic decode_plane(input int base);
      logic [31:0] s[8];
      logic [31:0] o[8];
      for (int c = 0; c < 8; c++) begin
         for (int k = 0; k < 8; k++)
            s[k] = {{16{coef_products[base + k*8 + c][15]}}, coef_products[base + k*8 + c]};
         idct_1d(s, 32'd512, o);
         for (int k = 0; k < 8; k++) col_scratch[k*8 + c] = asr(o[k], 10);
      end
      for (int r = 0; r < 8; r++) begin
         for (int k = 0; k < 8; k++) s[k] = col_scratch[r*8 + k];
         idct_1d(s, 32'd65536 + (32'd128 << 17), o);
         for (int k = 0; k < 8; k++) samples[base + r*8 + k] = clamp8(asr(o[k], 17));
      end
   endtask

   function automatic logic [31:0] ycc_to_bgra(input logic [7:0] y, input logic [7:0] cbv,
                                               input logic [7:0] crv);
      logic signed [31:0] yf, cb, cr, gcb, rr, gg, bb;
      yf = (32'(y) << 20) + (32'sd1 << 19);
      cb = 32'(cbv) - 128;
      cr = 32'(crv) - 128;
      gcb = cb * -(32'sd1410 * 256);
      gcb = gcb - (gcb & 32'h0000ffff);
      rr = asr(yf + cr * (32'sd5743 * 256), 20);
      gg = asr(yf + cr * -(32'sd2925 * 256) + gcb, 20);
      bb = asr(yf + cb * (32'sd7258 * 256), 20);
      return {8'hff, clamp8(rr), clamp8(gg), clamp8(bb)};
   endfunction

   // dequantize one item; on the last one of a tile queue all 64 pixels
   task automatic predict_item(input req_item_type it);
      logic [31:0] prod;
      rsp_item_type px;
      prod = {{16{it.coefficient[15]}}, it.coefficient} * {16'd0, it.quant_factor};
      coef_products[tile_pos] = prod[15:0];
      if (tile_pos < TileItems - 1) begin
         tile_pos++;
      end else begin
         tile_pos = 0;
         decode_plane(0);
         decode_plane(PlaneSize);
         decode_plane(2*PlaneSize);
         for (int i = 0; i < PlaneSize; i++) begin
            px.pixel_bgra = ycc_to_bgra(samples[i], samples[PlaneSize+i], samples[2*PlaneSize+i]);
            px.last_pixel = (i == PlaneSize - 1);
            expected_pixels.push_back(px);
         end
      end
   endtask

   // driver: start is randomly dropped between items, except while steady is set
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_item <= '0;
      end else begin
         if (start && !busy) begin
            predict_item(req_item);
            void'(pending_items.pop_front());
         end
         if (pending_items.size() > 0 && (steady || $urandom_range(99) >= 37)) begin
            start <= 1'b1;
            req_item <= pending_items[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel %h", rsp_item.pixel_bgra);
               error_count++;
            end else begin
               if (rsp_item.pixel_bgra !== expected_pixels[0].pixel_bgra) begin
                  $error("pixel_bgra expected %h actual %h",
                         expected_pixels[0].pixel_bgra, rsp_item.pixel_bgra);
                  error_count++;
               end
               if (rsp_item.last_pixel !== expected_pixels[0].last_pixel) begin
                  $error("last_pixel expected %b actual %b",
                         expected_pixels[0].last_pixel, rsp_item.last_pixel);
                  error_count++;
               end
               void'(expected_pixels.pop_front());
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("timeout: nothing accepted for %0d cycles", IdleLimit);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // build one tile of items; each plane picks its own coefficient style
   task automatic add_tile(input int mode_y, input int mode_cb, input int mode_cr);
      req_item_type it;
      int mode;
      for (int i = 0; i < TileItems; i++) begin
         mode = (i < PlaneSize) ? mode_y : ((i < 2*PlaneSize) ? mode_cb : mode_cr);
         case (mode)
            0: begin   // extremes everywhere
               it.coefficient = (i % 2) ? 16'sh7fff : -16'sh8000;
               it.quant_factor = (i % 3 == 0) ? 16'hffff : 16'(i % 3);
            end
            1: begin   // DC only per plane
               it.coefficient = (i % 64 == 0) ?
                  16'(int'($urandom_range(400)) - 200) : 16'sd0;
               it.quant_factor = 16'($urandom_range(16, 1));
            end
            2: begin   // realistic small AC content
               it.coefficient = 16'(int'($urandom_range(60)) - 30);
               it.quant_factor = 16'($urandom_range(40, 1));
            end
            default: begin   // full-range noise
               it.coefficient = 16'($urandom);
               it.quant_factor = 16'($urandom);
            end
         endcase
         pending_items.push_back(it);
      end
   endtask

   initial begin
      reset = 1'b1;
      tile_pos = 0;
      error_count = 0;
      pixels_seen = 0;
      idle_cycles = 0;
      steady = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // one tile: noisy luma, DC-only Cb, small AC content in Cr
      add_tile(3, 1, 2);
      wait (pending_items.size() <= 128);
      steady = 1'b1;
      wait (pending_items.size() <= 32);
      steady = 1'b0;
      wait (pending_items.size() == 0);
      wait (expected_pixels.size() == 0);
      repeat (50) @(posedge clock);
      $display("covered one tile of %0d items (noisy Y, DC-only Cb, smooth Cr), %0d pixels checked",
               TileItems, pixels_seen);
      if (error_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
